// ===== design/sacf_pkg.sv =====
// Shared types and constants for the set-associative cache tag store.
// No dependencies; used by sacf_cfg and set_assoc_cache_fifo_prefetch.
`default_nettype none

package sacf_pkg;

  // Parameter defaults for the top level.
  localparam int MAX_SETS_DEF   = 256;
  localparam int MAX_WAYS_DEF   = 8;
  localparam int ADDR_WIDTH_DEF = 48;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Result item width: hit, reads, write flag and four 32-bit totals, padded to bytes.
  localparam int CNT_W    = 32;
  localparam int OUT_BITS = 4 + 4 * CNT_W;
  localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

  // Register values after reset.
  localparam logic [3:0] OFFSET_BITS_RST = 4'd6;
  localparam logic [3:0] SET_BITS_RST    = 4'd0;
  localparam logic [3:0] WAYS_USED_RST   = 4'd1;
  localparam logic       PREFETCH_RST    = 1'b0;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [3:0] set_bits;
    logic [3:0] ways_used;
    logic       prefetch_enable;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/set_assoc_cache_fifo_prefetch.sv =====
// Tag store of a write-through, write-allocate set-associative cache with FIFO
// replacement and optional next-line prefetch. One access item yields one result
// item carrying the hit flag, the memory reads and write it caused, and the four
// running totals. The whole state of a set (valid bits, tags, FIFO pointer) is one
// row of a single tag RAM with registered read data. An access reads the tag row,
// then compares and writes back, waiting while the output is held; a miss with
// prefetch enabled adds a next-block lookup in the same RAM, forwarding the row just
// written when both blocks map to the same set. After reset the block sweeps the
// RAM once to clear it before the first item is taken; configuration writes are
// accepted during that time.
// Depends on sacf_pkg, sacf_cfg, sacf_lookup and sacf_ram.
`default_nettype none

module set_assoc_cache_fifo_prefetch #(
  parameter int MAX_SETS   = sacf_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS   = sacf_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH = sacf_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [sacf_pkg::APB_ADDR_W-1:0]        paddr,
  input  wire logic [sacf_pkg::APB_DATA_W-1:0]        pwdata,
  output logic      [sacf_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                        pready,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // address, zero padded to whole bytes
  input  wire logic [((ADDR_WIDTH + 7) / 8) * 8-1:0]  s_tdata,
  // operation (0 read, 1 write)
  input  wire logic                                   s_tuser,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // hit, reads_caused[1:0], write_caused, total_hits[31:0], total_misses[31:0],
  // total_reads[31:0], total_writes[31:0], zero padding
  output logic      [sacf_pkg::OUT_TW-1:0]            m_tdata
);

  localparam int SW     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int PW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW    = $clog2(MAX_WAYS + 1);
  localparam int RW     = MAX_WAYS + PW + MAX_WAYS * ADDR_WIDTH;
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int CW     = sacf_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK_D,
    S_LOOK_P
  } state_t;

  sacf_pkg::cfg_t cfg;

  state_t                state;
  logic [SW-1:0]         clr_idx;
  logic [SW-1:0]         d_set;
  logic [ADDR_WIDTH-1:0] d_tag;
  logic [SW-1:0]         p_set;
  logic [ADDR_WIDTH-1:0] p_tag;
  logic                  is_wr;
  logic                  fwd_valid;
  logic [RW-1:0]         fwd_row;
  logic [CW-1:0]         hit_cnt;
  logic [CW-1:0]         miss_cnt;
  logic [CW-1:0]         rd_cnt;
  logic [CW-1:0]         wr_cnt;
  logic                  o_hit;
  logic [1:0]            o_reads;
  logic                  o_write;

  // Address decode for the item at the input.
  logic [ADDR_WIDTH-1:0] addr;
  logic [ADDR_WIDTH-1:0] pf_addr;
  logic [ADDR_WIDTH-1:0] d_block;
  logic [ADDR_WIDTH-1:0] p_block;
  logic [3:0]            sb_eff;
  logic [4:0]            tag_sh;
  logic [SW-1:0]         set_mask;
  logic [SW-1:0]         a_d_set;
  logic [ADDR_WIDTH-1:0] a_d_tag;
  logic [SW-1:0]         a_p_set;
  logic [ADDR_WIDTH-1:0] a_p_tag;
  logic [WCW-1:0]        n_ways;

  // Tag RAM and lookup.
  logic                  ram_we;
  logic [SW-1:0]         ram_waddr;
  logic [RW-1:0]         ram_wdata;
  logic                  ram_re;
  logic [SW-1:0]         ram_raddr;
  logic [RW-1:0]         ram_rdata;
  logic [ADDR_WIDTH-1:0] lk_tag;
  logic [RW-1:0]         lk_row;
  logic                  lk_hit;
  logic [RW-1:0]         lk_row_next;

  logic                  out_free;
  logic                  fin;
  logic                  fin_hit;
  logic [1:0]            fin_reads;

  sacf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    addr     = s_tdata[ADDR_WIDTH-1:0];
    sb_eff   = (cfg.set_bits > 4'(SB_MAX)) ? 4'(SB_MAX) : cfg.set_bits;
    tag_sh   = 5'(cfg.offset_bits) + 5'(sb_eff);
    set_mask = SW'((32'd1 << sb_eff) - 32'd1);
    d_block  = addr >> cfg.offset_bits;
    a_d_set  = SW'(d_block) & set_mask;
    a_d_tag  = addr >> tag_sh;
    // The next block wraps within the address width.
    pf_addr  = addr + (ADDR_WIDTH'(1) << cfg.offset_bits);
    p_block  = pf_addr >> cfg.offset_bits;
    a_p_set  = SW'(p_block) & set_mask;
    a_p_tag  = pf_addr >> tag_sh;

    if (cfg.ways_used == 4'd0) begin
      n_ways = WCW'(1);
    end else if (32'(cfg.ways_used) > 32'(MAX_WAYS)) begin
      n_ways = WCW'(MAX_WAYS);
    end else begin
      n_ways = WCW'(cfg.ways_used);
    end
  end

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // One lookup unit serves both the demand and the prefetch pass.
  assign lk_tag = (state == S_LOOK_P) ? p_tag : d_tag;
  assign lk_row = (state == S_LOOK_P && fwd_valid) ? fwd_row : ram_rdata;

  sacf_lookup #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_lookup (
    .row      (lk_row),
    .tag      (lk_tag),
    .n_ways   (n_ways),
    .hit      (lk_hit),
    .row_next (lk_row_next)
  );

  sacf_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = d_set;
    ram_wdata = lk_row_next;
    ram_re    = 1'b0;
    ram_raddr = a_d_set;
    fin       = 1'b0;
    fin_hit   = 1'b0;
    fin_reads = 2'd0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_re = s_tvalid;
      end
      S_LOOK_D: begin
        if (out_free) begin
          ram_we    = !lk_hit;
          ram_re    = !lk_hit && cfg.prefetch_enable;
          ram_raddr = p_set;
          fin       = lk_hit || !cfg.prefetch_enable;
          fin_hit   = lk_hit;
          fin_reads = lk_hit ? 2'd0 : 2'd1;
        end
      end
      S_LOOK_P: begin
        if (out_free) begin
          ram_we    = !lk_hit;
          ram_waddr = p_set;
          fin       = 1'b1;
          fin_reads = lk_hit ? 2'd1 : 2'd2;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      fwd_valid <= 1'b0;
      m_tvalid  <= 1'b0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      rd_cnt    <= '0;
      wr_cnt    <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + SW'(1);
          if (clr_idx == SW'(MAX_SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            d_set <= a_d_set;
            d_tag <= a_d_tag;
            p_set <= a_p_set;
            p_tag <= a_p_tag;
            is_wr <= s_tuser;
            state <= S_LOOK_D;
          end
        end
        S_LOOK_D: begin
          if (out_free) begin
            if (fin) begin
              state <= S_IDLE;
            end else begin
              // The RAM returns the old row if the next block shares the set.
              fwd_valid <= (p_set == d_set);
              fwd_row   <= lk_row_next;
              state     <= S_LOOK_P;
            end
          end
        end
        S_LOOK_P: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
      if (fin) begin
        hit_cnt  <= hit_cnt + CW'(fin_hit);
        miss_cnt <= miss_cnt + CW'(!fin_hit);
        rd_cnt   <= rd_cnt + CW'(fin_reads);
        wr_cnt   <= wr_cnt + CW'(is_wr);
        o_hit    <= fin_hit;
        o_reads  <= fin_reads;
        o_write  <= is_wr;
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(sacf_pkg::OUT_TW - sacf_pkg::OUT_BITS)'(0),
                    wr_cnt, rd_cnt, miss_cnt, hit_cnt, o_write, o_reads, o_hit};

`ifndef ASSERT_OFF
  a_one_count: assert property (@(posedge clk) disable iff (rst)
    fin |=> (hit_cnt + miss_cnt) == ($past(hit_cnt + miss_cnt) + 32'd1))
    else $error("each finished item must count exactly one hit or miss");

  a_hit_no_read: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_hit) |-> (o_reads == 2'd0))
    else $error("a hit must not cause a memory read");

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_LOOK_D))
    else $error("an accepted item must go to the demand lookup");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state != S_IDLE))
    else $error("tag RAM written while idle");

  a_fwd_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK_P) |-> (fwd_valid == (p_set == d_set)))
    else $error("prefetch forwarding flag does not match the set compare");
`endif

endmodule

`default_nettype wire

// ===== design/sacf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sacf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/sacf_lookup.sv =====
// Way compare and FIFO fill logic on one set row of the tag memory.
// No package dependencies; instantiated by set_assoc_cache_fifo_prefetch.
`default_nettype none

module sacf_lookup #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 48
) (
  input  wire logic [MAX_WAYS + (MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)
                     + MAX_WAYS * ADDR_WIDTH - 1:0] row,
  input  wire logic [ADDR_WIDTH-1:0]               tag,
  input  wire logic [$clog2(MAX_WAYS + 1)-1:0]     n_ways,
  output logic                                     hit,
  output logic      [MAX_WAYS + (MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)
                     + MAX_WAYS * ADDR_WIDTH - 1:0] row_next
);

  localparam int PW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW  = $clog2(MAX_WAYS + 1);
  localparam int TAGS = MAX_WAYS * ADDR_WIDTH;

  // Row layout, low to high: tags of all ways, FIFO pointer, valid bits.
  logic [ADDR_WIDTH-1:0] tags [MAX_WAYS];
  logic [MAX_WAYS-1:0]   valid;
  logic [PW-1:0]         ptr;
  logic [MAX_WAYS-1:0]   match_v;
  logic [MAX_WAYS-1:0]   inv_v;
  logic                  found;
  logic                  first_hit;
  logic [PW-1:0]         first_way;
  logic [PW-1:0]         fifo_way;
  logic [WCW-1:0]        ptr_inc;
  logic [PW-1:0]         fill_way;
  logic [PW-1:0]         ptr_new;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      tags[w]    = row[w*ADDR_WIDTH +: ADDR_WIDTH];
      match_v[w] = (WCW'(w) < n_ways) && row[TAGS + PW + w] &&
                   (row[w*ADDR_WIDTH +: ADDR_WIDTH] == tag);
      inv_v[w]   = (WCW'(w) < n_ways) && !row[TAGS + PW + w];
    end
    valid = row[TAGS + PW +: MAX_WAYS];
    ptr   = row[TAGS +: PW];

    // The scan stops at the first way that either matches or is empty.
    found     = 1'b0;
    first_hit = 1'b0;
    first_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!found && (match_v[w] || inv_v[w])) begin
        found     = 1'b1;
        first_hit = match_v[w];
        first_way = PW'(w);
      end
    end
    hit = found && first_hit;

    // A pointer left over from a larger way count selects way zero.
    fifo_way = (WCW'(ptr) >= n_ways) ? '0 : ptr;
    ptr_inc  = WCW'(fifo_way) + WCW'(1);
    if (found) begin
      fill_way = first_way;
      ptr_new  = ptr;
    end else begin
      fill_way = fifo_way;
      ptr_new  = (ptr_inc >= n_ways) ? '0 : PW'(ptr_inc);
    end

    row_next = row;
    if (!hit) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (PW'(w) == fill_way) begin
          row_next[w*ADDR_WIDTH +: ADDR_WIDTH] = tag;
          row_next[TAGS + PW + w]              = 1'b1;
        end else begin
          row_next[w*ADDR_WIDTH +: ADDR_WIDTH] = tags[w];
          row_next[TAGS + PW + w]              = valid[w];
        end
      end
      row_next[TAGS +: PW] = ptr_new;
    end
  end

endmodule

`default_nettype wire

// ===== design/sacf_cfg.sv =====
// Configuration register file behind a simple APB-style port.
// Depends on sacf_pkg for the register struct and reset values.
`default_nettype none

module sacf_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sacf_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [sacf_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [sacf_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output sacf_pkg::cfg_t                       cfg
);

  typedef enum logic [1:0] {
    REG_OFFSET   = 2'd0,
    REG_SETS     = 2'd1,
    REG_WAYS     = 2'd2,
    REG_PREFETCH = 2'd3
  } reg_idx_t;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_bits     <= sacf_pkg::OFFSET_BITS_RST;
      cfg.set_bits        <= sacf_pkg::SET_BITS_RST;
      cfg.ways_used       <= sacf_pkg::WAYS_USED_RST;
      cfg.prefetch_enable <= sacf_pkg::PREFETCH_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_OFFSET:   cfg.offset_bits     <= pwdata[3:0];
        REG_SETS:     cfg.set_bits        <= pwdata[3:0];
        REG_WAYS:     cfg.ways_used       <= pwdata[3:0];
        REG_PREFETCH: cfg.prefetch_enable <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OFFSET:   prdata = {28'd0, cfg.offset_bits};
      REG_SETS:     prdata = {28'd0, cfg.set_bits};
      REG_WAYS:     prdata = {28'd0, cfg.ways_used};
      REG_PREFETCH: prdata = {31'd0, cfg.prefetch_enable};
    endcase
  end

endmodule

`default_nettype wire
